### hw/rtl/ifmt_pkg.sv
// Shared types and constants for the integer field formatter.
package ifmt_pkg;

    // Conversion codes carried in t_req.command
    localparam logic CMD_DEC = 1'b0;    // signed decimal
    localparam logic CMD_HEX = 1'b1;    // unsigned lower-case hex

    // Request word: one conversion request.
    typedef struct packed {
        logic        command;        // CMD_DEC or CMD_HEX
        logic [31:0] value;
        logic [5:0]  width;
        logic        has_precision;
        logic [5:0]  precision;
    } t_req;

    // Result word: one output character.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_HEX,
        S_SIZE,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic hex;
        logic size;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic skip;         // zero value with explicit zero precision
        logic is_hex;
        logic quot_zero;    // decimal quotient of this step is zero
        logic hex_rest_zero;
        logic total_zero;   // request emits nothing
        logic last;
    } t_dp_sts;

    localparam int          DIGIT_SLOTS = 10;   // most digits of a 32-bit value
    localparam int          NDIG_W      = 4;
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;  // ceil(2^35 / 10)
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

endpackage

### hw/rtl/integer_field_formatter.sv
// Top level of the integer field formatter: controller plus datapath.
//
// Formats one 32-bit value as %d (signed decimal) or %x (lower-case hex)
// with a minimum field width and an optional precision, one ASCII
// character per result word. A request word is taken at a clock edge with
// start high and busy low; busy then stays high until the last character
// has gone out. Characters come out on o_res in consecutive cycles, each
// marked by o_valid for exactly one cycle, with o_res.last on the final
// one; the receiver must take them as they come. Order is: pad spaces,
// minus sign, precision zeros, digits. A zero value with an explicit
// precision of zero prints no digits, so a request may produce no word.
// Per request: a setup step, then digit extraction (skipped when no
// digits are printed), a sizing step, then the characters. Decimal
// takes two steps per digit (a 32x32 reciprocal multiply, registered,
// then the remainder step), hex one step per digit. The next request
// can be taken as soon as busy is low. Width and precision above
// MAX_FIELD saturate to it.
module integer_field_formatter import ifmt_pkg::*; #(
    parameter int MAX_FIELD = 63
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ifmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    ifmt_datapath #(
        .MAX_FIELD (MAX_FIELD)
    ) u_datapath (
        .i_clk (i_clk),
        .i_req (i_req),
        .i_cmd (w_cmd),
        .o_sts (w_sts),
        .o_res (o_res)
    );

endmodule

### hw/rtl/ifmt_ctrl.sv
// Sequencing state machine of the integer field formatter.
module ifmt_ctrl import ifmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy,
    output logic    o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (i_sts.skip)        n_state = S_SIZE;
                else if (i_sts.is_hex) n_state = S_HEX;
                else                   n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = i_sts.quot_zero ? S_SIZE : S_MUL;
            end
            S_HEX: begin
                if (i_sts.hex_rest_zero) n_state = S_SIZE;
            end
            S_SIZE: begin
                n_state = i_sts.total_zero ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_SETUP: begin
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
            end
            S_HEX: begin
                o_cmd.hex = 1'b1;
            end
            S_SIZE: begin
                o_cmd.size = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                o_valid    = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/ifmt_datapath.sv
// Digit extraction, field sizing and character selection.
module ifmt_datapath import ifmt_pkg::*; #(
    parameter int MAX_FIELD = 63
) (
    input  logic    i_clk,
    input  t_req    i_req,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_res    o_res
);

    logic              r_hex;
    logic              r_neg;
    logic              r_skip;
    logic [31:0]       r_mag;
    logic [63:0]       r_prod;
    logic [5:0]        r_fw;
    logic [5:0]        r_prec;
    logic [NDIG_W-1:0] r_nd;
    logic [5:0]        r_spaces;
    logic [5:0]        r_zeros;
    logic [6:0]        r_left;
    logic [3:0]        r_stack [DIGIT_SLOTS];

    logic [31:0] w_mag_in;
    logic [5:0]  w_fw_in;
    logic [5:0]  w_prec_in;
    logic [31:0] w_quot;
    logic [31:0] w_rem;
    logic [63:0] w_prod;
    logic [5:0]  w_zeros;
    logic [6:0]  w_content;
    logic [5:0]  w_spaces;
    logic [6:0]  w_total;
    logic        w_push;
    logic [3:0]  w_digit;
    logic        w_neg_in;

    assign w_neg_in  = (i_req.command == CMD_DEC) && i_req.value[31];
    assign w_mag_in  = w_neg_in ? (~i_req.value + 32'd1) : i_req.value;
    assign w_fw_in   = (i_req.width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : i_req.width;
    assign w_prec_in = !i_req.has_precision ? 6'd0 :
                       (i_req.precision > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : i_req.precision;

    // divide by ten: reciprocal product, then remainder by shift-add
    assign w_prod  = r_mag * RECIP10;
    assign w_quot  = {{RECIP_SHIFT - 32{1'b0}}, r_prod[63:RECIP_SHIFT]};
    assign w_rem   = r_mag - ({w_quot[28:0], 3'b000} + {w_quot[30:0], 1'b0});

    assign w_push  = i_cmd.div | i_cmd.hex;
    assign w_digit = i_cmd.hex ? r_mag[3:0] : w_rem[3:0];

    assign w_zeros   = (r_prec > {2'b00, r_nd}) ? (r_prec - {2'b00, r_nd}) : 6'd0;
    assign w_content = {6'd0, r_neg} + {1'b0, w_zeros} + {3'b000, r_nd};
    assign w_spaces  = ({1'b0, r_fw} > w_content) ? 6'({1'b0, r_fw} - w_content) : 6'd0;
    assign w_total   = {1'b0, w_spaces} + w_content;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hex  <= (i_req.command == CMD_HEX);
            r_neg  <= w_neg_in;
            r_mag  <= w_mag_in;
            r_fw   <= w_fw_in;
            r_prec <= w_prec_in;
            r_skip <= i_req.has_precision && (i_req.precision == 6'd0)
                      && (i_req.value == 32'd0);
            r_nd   <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div) begin
            r_mag <= w_quot;
        end
        if (i_cmd.hex) begin
            r_mag <= {4'h0, r_mag[31:4]};
        end
        if (w_push) begin
            r_nd <= r_nd + 1'b1;
        end
        if (i_cmd.size) begin
            r_zeros  <= w_zeros;
            r_spaces <= w_spaces;
            r_left   <= w_total;
        end
        if (i_cmd.emit) begin
            r_left <= r_left - 7'd1;
            if (r_spaces != 6'd0) begin
                r_spaces <= r_spaces - 6'd1;
            end else if (r_neg) begin
                r_neg <= 1'b0;
            end else if (r_zeros != 6'd0) begin
                r_zeros <= r_zeros - 6'd1;
            end else begin
                r_nd <= r_nd - 1'b1;
            end
        end
    end

    // digit stack: pushed least significant first, popped from slot 0
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[0] <= w_digit;
            for (int i = 1; i < DIGIT_SLOTS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.emit && r_spaces == 6'd0 && !r_neg && r_zeros == 6'd0) begin
            for (int i = 0; i < DIGIT_SLOTS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_comb begin
        if (r_spaces != 6'd0)     o_res.out_char = CHAR_SPACE;
        else if (r_neg)           o_res.out_char = CHAR_MINUS;
        else if (r_zeros != 6'd0) o_res.out_char = CHAR_ZERO;
        else                      o_res.out_char = DIGIT_CHARS[r_stack[0]];
        o_res.last = (r_left == 7'd1);
    end

    assign o_sts.skip          = r_skip;
    assign o_sts.is_hex        = r_hex;
    assign o_sts.quot_zero     = (r_prod[63:RECIP_SHIFT] == '0);
    assign o_sts.hex_rest_zero = (r_mag[31:4] == 28'd0);
    assign o_sts.total_zero    = (w_total == 7'd0);
    assign o_sts.last          = (r_left == 7'd1);

endmodule

### hw/rtl/ifmt_checker.sv
// Port-level checks for the integer field formatter, bound to the top level.
module ifmt_checker import ifmt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_res o_res
);

    // a result word only while a request is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result word outside a request");

    // an accepted request holds the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // the final word frees the block
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |=> !busy)
        else $error("block still busy after final word");

    // words of one request are back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.last) |=> o_valid)
        else $error("gap inside a character burst");

endmodule

bind integer_field_formatter ifmt_checker u_ifmt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

### dv/integer_field_formatter_tb.sv
// Self-checking testbench for the integer field formatter (%d / %x with width and precision).
`timescale 1ns / 100ps

module integer_field_formatter_tb;
    import ifmt_pkg::*;

    localparam int         FIELD_CAP     = 63;      // width/precision saturation point
    localparam int         MAX_DIGITS    = 16;
    localparam int         N_RANDOM      = 190;
    localparam int         N_QUIET_TAIL  = 40;      // final requests sent back to back
    localparam int         DRAIN_AT      = 90;      // random index of the mid-run drain
    localparam int         SETTLE_CYCLES = 100;     // > worst busy time of one request
    localparam int         MAX_REPORTS   = 10;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;

    // One entry of the sender's schedule: idle cycles before the word, or a
    // drain point where the sender holds off until every character is back.
    typedef struct {
        t_req        req;
        int unsigned gap;
        bit          drain;
    } t_pending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_res o_res;

    t_pending pend_q [$];
    t_res     exp_chars [$];        // characters still owed by the block, oldest first

    // Sender state, owned by the driver block
    t_pending    staged;
    bit          have_staged = 1'b0;
    bit          draining    = 1'b0;
    int unsigned hold        = 0;

    int n_errors   = 0;
    int n_accepted = 0;
    int n_dec      = 0;
    int n_hex      = 0;
    int n_silent   = 0;
    int n_checked  = 0;

    integer_field_formatter #(.MAX_FIELD(FIELD_CAP)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: expands one request word into the characters the block
    // must emit, in order: pad spaces, minus, precision zeros, digits.
    // ------------------------------------------------------------------
    function automatic void format_field(input t_req r);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] base;
        logic [3:0]  d;
        logic [7:0]  rev [MAX_DIGITS];
        logic [7:0]  line [$];
        int unsigned fw;
        int unsigned prec;
        int unsigned nd;
        int unsigned zeros;
        int unsigned content;
        int unsigned spaces;

        fw   = (r.width > FIELD_CAP) ? FIELD_CAP : r.width;
        prec = r.has_precision ? r.precision : 0;   // precision w/o dot is ignored
        if (prec > FIELD_CAP) prec = FIELD_CAP;

        // Only decimal is signed; most negative value negates to itself,
        // which is still the right magnitude when read unsigned.
        neg  = (r.command == CMD_DEC) && r.value[31];
        mag  = neg ? (~r.value + 32'd1) : r.value;
        base = (r.command == CMD_HEX) ? 32'd16 : 32'd10;

        // Zero with explicit zero precision prints no digits at all
        nd = 0;
        if (!(r.has_precision && prec == 0 && r.value == '0)) begin
            do begin
                d = 4'(mag % base);
                rev[nd] = (d < 4'd10) ? CHAR_ZERO + 8'(d) : CHAR_LOWER_A + 8'(d - 4'd10);
                mag = mag / base;
                nd++;
            end while (mag != 0 && nd < MAX_DIGITS);
        end

        zeros   = (prec > nd) ? prec - nd : 0;
        content = (neg ? 1 : 0) + zeros + nd;
        spaces  = (fw > content) ? fw - content : 0;

        repeat (spaces) line.push_back(CHAR_SPACE);
        if (neg) line.push_back(CHAR_MINUS);
        repeat (zeros) line.push_back(CHAR_ZERO);
        for (int i = nd; i > 0; i--) line.push_back(rev[i - 1]);

        foreach (line[k])
            exp_chars.push_back('{out_char: line[k], last: (k == line.size() - 1)});

        n_accepted++;
        if (r.command == CMD_HEX) n_hex++; else n_dec++;
        if (line.size() == 0) n_silent++;
    endfunction

    function automatic void note_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    task automatic add_req(input logic cmd, input logic [31:0] val, input int w,
                           input logic hasp, input int p, input int unsigned gap);
        t_pending e;
        e.req.command       = cmd;
        e.req.value         = val;
        e.req.width         = 6'(w);
        e.req.has_precision = hasp;
        e.req.precision     = 6'(p);
        e.gap               = gap;
        e.drain             = 1'b0;
        pend_q.push_back(e);
    endtask

    task automatic add_drain();
        t_pending e;
        e.req   = '0;
        e.gap   = 0;
        e.drain = 1'b1;
        pend_q.push_back(e);
    endtask

    // ------------------------------------------------------------------
    // Driver: a word is taken at an edge with start high and busy low.
    // start is held while busy; each step makes exactly one assignment
    // to start so back-to-back words never glitch it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        logic go;
        t_req nreq;
        go   = 1'b0;
        nreq = '0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) format_field(i_req);
            if (!(start && busy)) begin
                if (hold > 0) begin
                    hold--;
                end else if (draining) begin
                    // resume once the block is idle and owes nothing
                    if (exp_chars.size() == 0 && !busy) draining = 1'b0;
                end else if (have_staged) begin
                    go          = 1'b1;
                    nreq        = staged.req;
                    have_staged = 1'b0;
                end else if (pend_q.size() > 0) begin
                    staged = pend_q.pop_front();
                    if (staged.drain) begin
                        draining = 1'b1;
                    end else if (staged.gap > 0) begin
                        hold        = staged.gap - 1;   // this cycle is the first idle one
                        have_staged = 1'b1;
                    end else begin
                        go   = 1'b1;
                        nreq = staged.req;
                    end
                end
                start <= go;
                if (go) i_req <= nreq;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed word is checked against the oldest owed char.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_res want;
        if (i_rst_n && o_valid) begin
            if (exp_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected word char=%h last=%b",
                                        o_res.out_char, o_res.last));
            end else begin
                want = exp_chars.pop_front();
                n_checked++;
                if (o_res.out_char !== want.out_char)
                    note_mismatch($sformatf("char exp %h '%c' got %h '%c'", want.out_char,
                                            want.out_char, o_res.out_char, o_res.out_char));
                if (o_res.last !== want.last)
                    note_mismatch($sformatf("last exp %b got %b (char %h)",
                                            want.last, o_res.last, want.out_char));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stim
        logic [31:0] val;
        logic        hasp;
        int          w;
        int          p;
        int unsigned gap;

        // Directed: corners of every field and each special case
        add_req(CMD_DEC, 32'd0,        0,  1'b0, 0,  0);  // plain zero
        add_req(CMD_DEC, 32'd0,        0,  1'b1, 0,  0);  // zero, .0 -> nothing at all
        add_req(CMD_DEC, 32'd0,        5,  1'b1, 0,  3);  // zero, .0, width -> spaces only
        add_req(CMD_HEX, 32'd0,        0,  1'b1, 0,  0);  // hex flavor of the silent case
        add_req(CMD_HEX, 32'd0,        1,  1'b1, 0,  0);
        add_req(CMD_DEC, 32'h8000_0000, 0, 1'b0, 0,  0);  // most negative
        add_req(CMD_DEC, 32'h8000_0000, 0, 1'b1, 63, 0);  // 64 chars
        add_req(CMD_DEC, 32'hFFFF_FFFF, 63, 1'b1, 63, 0); // -1, 64 chars, no pad
        add_req(CMD_DEC, 32'hFFFF_FFFF, 63, 1'b1, 0, 2);
        add_req(CMD_DEC, 32'h7FFF_FFFF, 63, 1'b0, 0, 0);
        add_req(CMD_DEC, 32'd1000000000, 0, 1'b0, 0, 0);  // ten digits
        add_req(CMD_HEX, 32'hFFFF_FFFF, 0,  1'b0, 0, 0);
        add_req(CMD_HEX, 32'hDEAD_BEEF, 20, 1'b1, 12, 0);
        add_req(CMD_HEX, 32'h0123_4567, 8,  1'b1, 8,  0);
        add_req(CMD_HEX, 32'd0,        63, 1'b1, 63, 0);  // 63 zeros
        add_req(CMD_HEX, 32'd1,        1,  1'b0, 0,  0);
        add_req(CMD_DEC, 32'd123,      0,  1'b0, 63, 0);  // precision w/o dot ignored
        add_req(CMD_DEC, 32'd12345,    3,  1'b0, 0,  0);  // content wider than field
        add_req(CMD_DEC, 32'd12345,    5,  1'b0, 0,  0);  // exactly fits
        add_req(CMD_DEC, -32'sd42,     10, 1'b1, 5,  1);
        add_req(CMD_DEC, 32'd7,        0,  1'b1, 1,  0);
        add_drain();

        // Random: mostly realistic fields, some at full range
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 9))
                0:       val = 32'd0;
                1:       val = $urandom_range(0, 999);
                2:       val = -$urandom_range(1, 999);
                3: begin
                    case ($urandom_range(0, 3))
                        0:       val = 32'h8000_0000;
                        1:       val = 32'h7FFF_FFFF;
                        2:       val = 32'hFFFF_FFFF;
                        default: val = 32'd1 << $urandom_range(0, 31);
                    endcase
                end
                default: val = $urandom;
            endcase
            w    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 16);
            hasp = 1'($urandom_range(0, 1));
            p    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
            gap  = (i >= N_RANDOM - N_QUIET_TAIL || $urandom_range(0, 3) != 0)
                   ? 0 : $urandom_range(1, 14);
            add_req(1'($urandom_range(0, 1)), val, w, hasp, p, gap);
            if (i == DRAIN_AT) add_drain();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last word to be taken, then for every char to come back
        @(posedge i_clk);
        while (pend_q.size() != 0 || have_staged || draining || start) @(posedge i_clk);
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Formatted %0d requests (%0d decimal, %0d hex, %0d with no output),",
                 n_accepted, n_dec, n_hex, n_silent);
        $display("%0d chars checked; fields to width/precision %0d, sign and zero corners,",
                 n_checked, FIELD_CAP);
        $display("sender gaps and drains.");
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (~250 words, each at its worst busy time)
    initial begin : watchdog
        #1_000_000;
        $display("Timeout with %0d chars still owed", exp_chars.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
